// File: hw/rtl/sfr_pkg.sv
package sfr_pkg;

	localparam int unsigned DataW = 8;
	localparam int unsigned LenW = 16;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CrcW = 16;
	localparam logic [CrcW-1:0] CrcPolyRefl = 16'hA001;

	localparam logic [CfgIdxW-1:0] CFG_BEGIN_FLAG = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_ESCAPE_FLAG = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_ESCAPE_XOR = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 2'd3;

	localparam logic [DataW-1:0] BeginFlagRst = 8'h7E;
	localparam logic [DataW-1:0] EscapeFlagRst = 8'h7D;
	localparam logic [DataW-1:0] EscapeXorRst = 8'h20;
	localparam logic [LenW-1:0] MaxPayloadRst = 16'd512;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_FRAME_OK = 2'd1,
		KIND_CRC_BAD = 2'd2,
		KIND_TOO_LONG = 2'd3
	} kind_t;

	typedef struct packed {
		logic [DataW-1:0] begin_flag;
		logic [DataW-1:0] escape_flag;
		logic [DataW-1:0] escape_xor;
		logic [LenW-1:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic resync;
		logic [DataW-1:0] data;
	} token_t;

	function automatic logic [CrcW-1:0] crc_arc_byte(input logic [CrcW-1:0] crc_in,
			input logic [DataW-1:0] data);
		logic [CrcW-1:0] crc;
		crc = crc_in ^ {{(CrcW-DataW){1'b0}}, data};
		for (int i = 0; i < DataW; i++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CrcPolyRefl;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

// File: hw/rtl/sfr_front.sv
module sfr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sfr_pkg::cfg_t              cfg,
	input  logic                       rx_valid,
	output logic                       rx_ready,
	input  logic [sfr_pkg::DataW-1:0]  rx_byte,
	input  logic                       fifo_full,
	output logic                       tok_push,
	output sfr_pkg::token_t            tok
);

	logic esc_q;
	logic accept;
	logic is_begin;
	logic is_escape;

	always_comb begin
		rx_ready = !fifo_full;
		accept = rx_valid && rx_ready;
		is_begin = (rx_byte == cfg.begin_flag);
		is_escape = !esc_q && (rx_byte == cfg.escape_flag);
		tok.resync = is_begin;
		tok.data = esc_q ? (rx_byte ^ cfg.escape_xor) : rx_byte;
		tok_push = accept && (is_begin || !is_escape);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
		end else if (accept) begin
			esc_q <= !is_begin && is_escape;
		end
	end

endmodule

// File: hw/rtl/sfr_fifo.sv
module sfr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfr_pkg::token_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output sfr_pkg::token_t pop_data
);

	localparam int unsigned Depth = 4;
	localparam int unsigned PtrW = $clog2(Depth);

	sfr_pkg::token_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0] count_q;
	logic do_push;
	logic do_pop;

	always_comb begin
		full = (count_q == (PtrW+1)'(Depth));
		not_empty = (count_q != '0);
		pop_data = mem_q[rd_ptr_q];
		do_push = push && !full;
		do_pop = pop && not_empty;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/sfr_back.sv
module sfr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sfr_pkg::cfg_t              cfg,
	input  logic                       tok_valid,
	input  sfr_pkg::token_t            tok,
	output logic                       tok_pop,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [1:0]                 kind,
	output logic [sfr_pkg::DataW-1:0]  payload_byte,
	output logic [sfr_pkg::DataW-1:0]  source_address,
	output logic [sfr_pkg::DataW-1:0]  dest_address,
	output logic [sfr_pkg::LenW-1:0]   frame_length
);

	typedef enum logic [7:0] {
		PH_HUNT    = 8'b0000_0001,
		PH_SRC     = 8'b0000_0010,
		PH_DST     = 8'b0000_0100,
		PH_LEN_LO  = 8'b0000_1000,
		PH_LEN_HI  = 8'b0001_0000,
		PH_PAYLOAD = 8'b0010_0000,
		PH_CRC_LO  = 8'b0100_0000,
		PH_CRC_HI  = 8'b1000_0000
	} phase_t;

	phase_t phase_q, phase_d;
	logic [sfr_pkg::DataW-1:0] src_q, src_d;
	logic [sfr_pkg::DataW-1:0] dst_q, dst_d;
	logic [sfr_pkg::LenW-1:0] len_q, len_d;
	logic [sfr_pkg::LenW-1:0] pos_q, pos_d;
	logic [sfr_pkg::CrcW-1:0] crc_q, crc_d;
	logic [sfr_pkg::DataW-1:0] crc_lo_q, crc_lo_d;
	logic [sfr_pkg::LenW-1:0] pos_inc;
	logic [sfr_pkg::LenW-1:0] new_len;
	logic [sfr_pkg::CrcW-1:0] crc_next;
	logic emit;
	sfr_pkg::kind_t emit_kind;
	logic [sfr_pkg::DataW-1:0] emit_byte;

	logic res_valid_q;
	sfr_pkg::kind_t kind_q;
	logic [sfr_pkg::DataW-1:0] payload_q;
	logic [sfr_pkg::DataW-1:0] src_out_q;
	logic [sfr_pkg::DataW-1:0] dst_out_q;
	logic [sfr_pkg::LenW-1:0] len_out_q;

	always_comb begin
		tok_pop = tok_valid && (!res_valid_q || res_ready);
		phase_d = phase_q;
		src_d = src_q;
		dst_d = dst_q;
		len_d = len_q;
		pos_d = pos_q;
		crc_d = crc_q;
		crc_lo_d = crc_lo_q;
		emit = 1'b0;
		emit_kind = sfr_pkg::KIND_PAYLOAD;
		emit_byte = '0;
		pos_inc = pos_q + 1'b1;
		new_len = {tok.data, len_q[sfr_pkg::DataW-1:0]};
		crc_next = sfr_pkg::crc_arc_byte(crc_q, tok.data);
		if (tok.resync) begin
			phase_d = PH_SRC;
		end else begin
			case (phase_q)
				PH_HUNT: begin
					phase_d = PH_HUNT;
				end
				PH_SRC: begin
					src_d = tok.data;
					phase_d = PH_DST;
				end
				PH_DST: begin
					dst_d = tok.data;
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d = {{(sfr_pkg::LenW-sfr_pkg::DataW){1'b0}}, tok.data};
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_d = new_len;
					pos_d = '0;
					crc_d = '0;
					if (new_len > cfg.max_payload) begin
						phase_d = PH_HUNT;
						emit = 1'b1;
						emit_kind = sfr_pkg::KIND_TOO_LONG;
					end else if (new_len == '0) begin
						phase_d = PH_CRC_LO;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					crc_d = crc_next;
					pos_d = pos_inc;
					if (pos_inc >= len_q) begin
						phase_d = PH_CRC_LO;
					end
					emit = 1'b1;
					emit_kind = sfr_pkg::KIND_PAYLOAD;
					emit_byte = tok.data;
				end
				PH_CRC_LO: begin
					crc_lo_d = tok.data;
					phase_d = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					phase_d = PH_HUNT;
					emit = 1'b1;
					emit_kind = ({tok.data, crc_lo_q} == crc_q) ? sfr_pkg::KIND_FRAME_OK
						: sfr_pkg::KIND_CRC_BAD;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			src_q <= '0;
			dst_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			crc_q <= '0;
			crc_lo_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (tok_pop) begin
				phase_q <= phase_d;
				src_q <= src_d;
				dst_q <= dst_d;
				len_q <= len_d;
				pos_q <= pos_d;
				crc_q <= crc_d;
				crc_lo_q <= crc_lo_d;
				if (emit) begin
					res_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop && emit) begin
			kind_q <= emit_kind;
			payload_q <= emit_byte;
			src_out_q <= src_d;
			dst_out_q <= dst_d;
			len_out_q <= len_d;
		end
	end

	assign res_valid = res_valid_q;
	assign kind = kind_q;
	assign payload_byte = payload_q;
	assign source_address = src_out_q;
	assign dest_address = dst_out_q;
	assign frame_length = len_out_q;

endmodule

// File: hw/rtl/serial_frame_receiver_core.sv
// Receiver for byte-stuffed frames with a CRC-16/ARC check over the payload.
// The rx channel takes one raw line byte per request. The front end removes
// escapes and spots begin flags, and pushes the bytes that matter into a
// four-entry queue. The back end parses addresses, length, payload and CRC.
// The res channel carries one request for each payload byte and one verdict
// per frame: frame ok, CRC mismatch, or a length above max_payload.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only with no frame in flight; the block does not enforce it.
// A write takes effect on the next cycle. The back end parses one byte per
// cycle unless a pending result stalls it. A byte passes through the queue
// and its result through the output register, held there while res_ready is
// low, so the queue fills and rx_ready falls once all four entries are used.
// Reset clears the queue, the escape state and the parser, which returns to
// hunting for a begin flag, and restores the configuration reset values.
module serial_frame_receiver_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [sfr_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          rx_valid,
	output logic                          rx_ready,
	input  logic [sfr_pkg::DataW-1:0]     rx_byte,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [1:0]                    kind,
	output logic [sfr_pkg::DataW-1:0]     payload_byte,
	output logic [sfr_pkg::DataW-1:0]     source_address,
	output logic [sfr_pkg::DataW-1:0]     dest_address,
	output logic [sfr_pkg::LenW-1:0]      frame_length
);

	sfr_pkg::cfg_t cfg_q;
	logic fifo_full;
	logic tok_push;
	sfr_pkg::token_t push_tok;
	logic tok_pop;
	logic tok_valid;
	sfr_pkg::token_t pop_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.begin_flag <= sfr_pkg::BeginFlagRst;
			cfg_q.escape_flag <= sfr_pkg::EscapeFlagRst;
			cfg_q.escape_xor <= sfr_pkg::EscapeXorRst;
			cfg_q.max_payload <= sfr_pkg::MaxPayloadRst;
		end else if (cfg_we) begin
			case (cfg_index)
				sfr_pkg::CFG_BEGIN_FLAG: begin
					cfg_q.begin_flag <= cfg_data[sfr_pkg::DataW-1:0];
				end
				sfr_pkg::CFG_ESCAPE_FLAG: begin
					cfg_q.escape_flag <= cfg_data[sfr_pkg::DataW-1:0];
				end
				sfr_pkg::CFG_ESCAPE_XOR: begin
					cfg_q.escape_xor <= cfg_data[sfr_pkg::DataW-1:0];
				end
				sfr_pkg::CFG_MAX_PAYLOAD: begin
					cfg_q.max_payload <= cfg_data[sfr_pkg::LenW-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	sfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.fifo_full(fifo_full),
		.tok_push (tok_push),
		.tok      (push_tok)
	);

	sfr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (tok_push),
		.push_data(push_tok),
		.full     (fifo_full),
		.pop      (tok_pop),
		.not_empty(tok_valid),
		.pop_data (pop_tok)
	);

	sfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.tok_valid     (tok_valid),
		.tok           (pop_tok),
		.tok_pop       (tok_pop),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.source_address(source_address),
		.dest_address  (dest_address),
		.frame_length  (frame_length)
	);

endmodule
